@@ hw/rtl/pmwe_pkg.sv @@
// ----------------------------------------------------------------------------
// pmwe_pkg
// Shared types and constants of the pause merging wait encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pmwe_pkg;

    localparam int ACC_WIDTH = 21;

    typedef logic [ACC_WIDTH-1:0] acc_t;

    localparam acc_t MAX_WAIT  = acc_t'(16'hffff);
    localparam acc_t ACC_MAX   = {ACC_WIDTH{1'b1}};
    localparam acc_t SHORT_MAX = acc_t'(16);
    localparam acc_t LEN_60TH  = acc_t'(735);
    localparam acc_t LEN_50TH  = acc_t'(882);
    localparam acc_t LEN_60TH2 = acc_t'(1470);
    localparam acc_t LEN_50TH2 = acc_t'(1764);

    typedef enum logic [1:0] {
        FUNC_PAUSE = 2'd0,
        FUNC_PASS  = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_SPARE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_WAIT16 = 3'd0,
        KIND_W60    = 3'd1,
        KIND_W50    = 3'd2,
        KIND_SHORT  = 3'd3,
        KIND_PASS   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WAIT,
        BK_DUP,
        BK_PASS
    } back_state_t;

    // flush job handed from front to back
    typedef struct packed {
        logic        pass;
        logic [15:0] cmd_ref;
        acc_t        total;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/pmwe_queue.sv @@
// ----------------------------------------------------------------------------
// pmwe_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pmwe_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire pmwe_pkg::job_t         push_job,
    input  wire logic                   pop,
    output pmwe_pkg::job_t              pop_job,
    output pmwe_pkg::queue_status_t     status
);
    import pmwe_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pmwe_front.sv @@
// ----------------------------------------------------------------------------
// pmwe_front
// Accepts input words, merges pauses into a saturating total and queues
// flush jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module pmwe_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             func,
    input  wire logic [15:0]            pause_samples,
    input  wire logic [15:0]            cmd_ref,
    input  wire pmwe_pkg::queue_status_t q_status,
    output logic                        push,
    output pmwe_pkg::job_t              push_job
);
    import pmwe_pkg::*;

    acc_t               pending_reg;
    acc_t               pending_next;
    logic [ACC_WIDTH:0] sum;
    logic               accept;
    logic               is_pause;
    logic               is_pass;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_pause = (func_t'(func) == FUNC_PAUSE);
    assign is_pass  = (func_t'(func) == FUNC_PASS);
    assign sum      = {1'b0, pending_reg} + {{(ACC_WIDTH + 1 - 16){1'b0}}, pause_samples};

    assign push_job.pass    = is_pass;
    assign push_job.cmd_ref = cmd_ref;
    assign push_job.total   = pending_reg;

    always_comb
    begin
        pending_next = pending_reg;
        push         = 1'b0;
        if (accept)
        begin
            if (is_pause)
            begin
                pending_next = sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];
            end
            else
            begin
                pending_next = '0;
                push         = is_pass || (pending_reg != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pmwe_back.sv @@
// ----------------------------------------------------------------------------
// pmwe_back
// Drains flush jobs into wait and passthrough result words.
// ----------------------------------------------------------------------------
`default_nettype none

module pmwe_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pmwe_pkg::queue_status_t q_status,
    input  wire pmwe_pkg::job_t         pop_job,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2:0]                  out_kind,
    output logic [15:0]                 out_samples,
    output logic [15:0]                 out_ref,
    output logic                        last
);
    import pmwe_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    acc_t        rem_reg;
    acc_t        rem_next;
    logic [15:0] ref_reg;
    logic [15:0] ref_next;
    logic        pass_reg;
    logic        pass_next;
    kind_t       dup_reg;
    kind_t       dup_next;
    logic        valid_reg;
    kind_t       kind_reg;
    logic [15:0] samples_reg;
    logic [15:0] ref_out_reg;
    logic        last_reg;

    logic        load;
    logic        can_load;
    kind_t       e_kind;
    logic [15:0] e_samples;
    logic [15:0] e_ref;
    logic        e_last;
    back_state_t after_rem;

    assign can_load  = !valid_reg || out_ready;
    assign after_rem = pass_reg ? BK_PASS : BK_IDLE;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        ref_next   = ref_reg;
        pass_next  = pass_reg;
        dup_next   = dup_reg;
        pop        = 1'b0;
        load       = 1'b0;
        e_kind     = KIND_WAIT16;
        e_samples  = 16'd0;
        e_ref      = 16'd0;
        e_last     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    rem_next   = pop_job.total;
                    ref_next   = pop_job.cmd_ref;
                    pass_next  = pop_job.pass;
                    state_next = (pop_job.total == '0) ? BK_PASS : BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                if (can_load)
                begin
                    load = 1'b1;
                    if (rem_reg > MAX_WAIT)
                    begin
                        e_kind    = KIND_WAIT16;
                        e_samples = 16'hffff;
                        rem_next  = rem_reg - MAX_WAIT;
                    end
                    else
                    begin
                        state_next = after_rem;
                        e_last     = !pass_reg;
                        if (rem_reg == LEN_60TH2)
                        begin
                            e_kind     = KIND_W60;
                            e_last     = 1'b0;
                            dup_next   = KIND_W60;
                            state_next = BK_DUP;
                        end
                        else if (rem_reg == LEN_60TH)
                            e_kind = KIND_W60;
                        else if (rem_reg == LEN_50TH2)
                        begin
                            e_kind     = KIND_W50;
                            e_last     = 1'b0;
                            dup_next   = KIND_W50;
                            state_next = BK_DUP;
                        end
                        else if (rem_reg == LEN_50TH)
                            e_kind = KIND_W50;
                        else if (rem_reg <= SHORT_MAX)
                        begin
                            e_kind    = KIND_SHORT;
                            e_samples = rem_reg[15:0];
                        end
                        else
                        begin
                            e_kind    = KIND_WAIT16;
                            e_samples = rem_reg[15:0];
                        end
                    end
                end
            end
            BK_DUP:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    e_kind     = dup_reg;
                    e_last     = !pass_reg;
                    state_next = after_rem;
                end
            end
            BK_PASS:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    e_kind     = KIND_PASS;
                    e_ref      = ref_reg;
                    e_last     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        ref_reg  <= ref_next;
        pass_reg <= pass_next;
        dup_reg  <= dup_next;
        if (load)
        begin
            kind_reg    <= e_kind;
            samples_reg <= e_samples;
            ref_out_reg <= e_ref;
            last_reg    <= e_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_samples = samples_reg;
    assign out_ref     = ref_out_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pause_merge_wait_encoder.sv @@
// ----------------------------------------------------------------------------
// pause_merge_wait_encoder
// Merges pause commands into a saturating total and encodes flushed totals
// as wait words and passes passthrough commands through.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------
//  in      | in_valid / in_ready | func, pause_samples, cmd_ref
//  out     | out_valid/out_ready | out_kind, out_samples, out_ref, last
//
//  One input word per cycle while in_ready is high; pauses are taken while
//  results drain. A passthrough word, or a flush with a nonzero total, takes
//  a queue slot; in_ready drops while the two-entry queue is full.
//  The back emits one result word per cycle while out_ready is high, from its
//  output register, and fetches each job in its idle state before its results.
//  Reset clears the pause total, queue and output valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pause_merge_wait_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] pause_samples,
    input  wire logic [15:0] cmd_ref,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_kind,
    output logic [15:0]      out_samples,
    output logic [15:0]      out_ref,
    output logic             last
);
    import pmwe_pkg::*;

    queue_status_t q_status;
    job_t          push_job;
    job_t          pop_job;
    logic          push;
    logic          pop;

    pmwe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .pause_samples (pause_samples),
        .cmd_ref       (cmd_ref),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    pmwe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    pmwe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .pop_job     (pop_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_kind    (out_kind),
        .out_samples (out_samples),
        .out_ref     (out_ref),
        .last        (last)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pause_merge_wait_encoder: directed and random
// command streams with merged pauses, wait encoding, passthrough and flush,
// under random output backpressure and random input gaps.
// ----------------------------------------------------------------------------
module tb;

    import pmwe_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 210;

    typedef struct {
        func_t       fn;
        logic [15:0] samples;
        logic [15:0] handle;
        bit          drain;
    } cmd_word_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] samples;
        logic [15:0] handle;
        logic        last;
    } enc_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = 2'd0;
    logic [15:0] pause_samples = 16'd0;
    logic [15:0] cmd_ref = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  out_kind;
    logic [15:0] out_samples;
    logic [15:0] out_ref;
    logic        last;

    cmd_word_t cmd_backlog[$];
    enc_word_t enc_due[$];
    cmd_word_t cur_word;
    acc_t      pause_total = '0;
    logic      calm = 1'b0;

    int errors = 0;
    int cycles = 0;
    int words_queued = 0;
    int words_accepted = 0;
    int results_seen = 0;
    int clips = 0;
    int longest_burst = 0;
    int kind_seen[5] = '{0, 0, 0, 0, 0};

    pause_merge_wait_encoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .pause_samples (pause_samples),
        .cmd_ref       (cmd_ref),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (out_kind),
        .out_samples   (out_samples),
        .out_ref       (out_ref),
        .last          (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic enc_word_t make_enc(input kind_t kind, input logic [15:0] samples,
                                           input logic [15:0] handle);
        enc_word_t e;
        e.kind = kind;
        e.samples = samples;
        e.handle = handle;
        e.last = 1'b0;
        return e;
    endfunction

    // pauses accumulate; anything else flushes the total, then a pass word passes through
    task automatic merge_and_encode(input cmd_word_t w);
        logic [ACC_WIDTH:0] sum;
        acc_t               rest;
        enc_word_t          batch[$];
        enc_word_t          e;
        int                 i;
        if (w.fn == FUNC_PAUSE)
        begin
            sum = {1'b0, pause_total} + {{(ACC_WIDTH + 1 - 16){1'b0}}, w.samples};
            if (sum > ACC_MAX)
            begin
                pause_total = ACC_MAX;
                clips++;
            end
            else
                pause_total = sum[ACC_WIDTH-1:0];
        end
        else
        begin
            rest = pause_total;
            pause_total = '0;
            if (rest != '0)
            begin
                while (rest > MAX_WAIT)
                begin
                    batch.insert(batch.size(), make_enc(KIND_WAIT16, 16'hffff, 16'h0));
                    rest = rest - MAX_WAIT;
                end
                if (rest == LEN_60TH2)
                begin
                    batch.insert(batch.size(), make_enc(KIND_W60, 16'h0, 16'h0));
                    batch.insert(batch.size(), make_enc(KIND_W60, 16'h0, 16'h0));
                end
                else if (rest == LEN_60TH)
                    batch.insert(batch.size(), make_enc(KIND_W60, 16'h0, 16'h0));
                else if (rest == LEN_50TH2)
                begin
                    batch.insert(batch.size(), make_enc(KIND_W50, 16'h0, 16'h0));
                    batch.insert(batch.size(), make_enc(KIND_W50, 16'h0, 16'h0));
                end
                else if (rest == LEN_50TH)
                    batch.insert(batch.size(), make_enc(KIND_W50, 16'h0, 16'h0));
                else if (rest <= SHORT_MAX)
                    batch.insert(batch.size(), make_enc(KIND_SHORT, rest[15:0], 16'h0));
                else
                    batch.insert(batch.size(), make_enc(KIND_WAIT16, rest[15:0], 16'h0));
            end
            if (w.fn == FUNC_PASS)
                batch.insert(batch.size(), make_enc(KIND_PASS, 16'h0, w.handle));
            for (i = 0; i < batch.size(); i++)
            begin
                e = batch[i];
                e.last = (i == batch.size() - 1);
                enc_due.insert(enc_due.size(), e);
            end
            if (batch.size() > longest_burst)
                longest_burst = batch.size();
        end
    endtask

    // unused field of each word gets random content
    task automatic queue_cmd(input func_t fn, input int payload, input bit drain);
        cmd_word_t w;
        w.fn = fn;
        w.drain = drain;
        w.samples = (fn == FUNC_PAUSE) ? payload[15:0] : 16'($urandom_range(0, 65535));
        w.handle = (fn == FUNC_PAUSE) ? 16'($urandom_range(0, 65535)) : payload[15:0];
        cmd_backlog.insert(cmd_backlog.size(), w);
        words_queued++;
    endtask

    task automatic queue_end_word();
        int r;
        r = $urandom_range(0, 9);
        queue_cmd(r < 6 ? FUNC_PASS : (r < 9 ? FUNC_FLUSH : FUNC_SPARE),
                  $urandom_range(0, 65535), $urandom_range(0, 24) == 0);
    endtask

    task automatic queue_total(input int target);
        int pieces;
        int lim;
        int p;
        pieces = 0;
        while (target > 0)
        begin
            lim = (target > 65535) ? 65535 : target;
            if (pieces >= 2 || $urandom_range(0, 1) == 1)
                p = lim;
            else
                p = $urandom_range(0, lim);
            queue_cmd(FUNC_PAUSE, p, 1'b0);
            if ($urandom_range(0, 7) == 0)
                queue_cmd(FUNC_PAUSE, 0, 1'b0);
            target -= p;
            pieces++;
        end
    endtask

    function automatic int special_total(input int sel);
        case (sel)
            0: return 735;
            1: return 882;
            2: return 1470;
            3: return 1764;
            4: return 1;
            5: return 16;
            6: return 17;
            7: return 734;
            8: return 736;
            9: return 1471;
            10: return 1763;
            11: return 65535;
            12: return 65536;
            13: return 65535 + 735;
            14: return 65535 + 1470;
            15: return 65535 + 882;
            16: return 65535 + 1764;
            17: return 65535 + 16;
            18: return 131070;
            19: return 131070 + 1470;
            default: return 131071;
        endcase
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                merge_and_encode(cur_word);
                words_accepted++;
            end
            calm <= (words_accepted >= 90 && words_accepted < 150);
            if (!in_valid || in_ready)
            begin
                if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 36) &&
                    !(cmd_backlog[0].drain && enc_due.size() != 0))
                begin
                    cur_word = cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    func <= cur_word.fn;
                    pause_samples <= cur_word.samples;
                    cmd_ref <= cur_word.handle;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        enc_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_kind < 3'd5)
                kind_seen[out_kind]++;
            if (enc_due.size() == 0)
            begin
                $error("unexpected result word: kind %0d samples %0d ref %0d",
                       out_kind, out_samples, out_ref);
                errors++;
            end
            else
            begin
                e = enc_due.pop_front();
                if (out_kind !== e.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", e.kind, out_kind);
                    errors++;
                end
                if (out_samples !== e.samples)
                begin
                    $error("out_samples: expected %0d, got %0d", e.samples, out_samples);
                    errors++;
                end
                if (out_ref !== e.handle)
                begin
                    $error("out_ref: expected %0h, got %0h", e.handle, out_ref);
                    errors++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0b, got %0b", e.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int r;
        int k;
        int i;

        // directed
        queue_cmd(FUNC_FLUSH, 0, 1'b0);
        queue_cmd(FUNC_PASS, 16'hffff, 1'b0);
        queue_cmd(FUNC_PAUSE, 0, 1'b0);
        queue_cmd(FUNC_PASS, 0, 1'b0);
        queue_cmd(FUNC_PAUSE, 735, 1'b0);
        queue_cmd(FUNC_SPARE, 16'h1234, 1'b0);
        queue_cmd(FUNC_PAUSE, 700, 1'b0);
        queue_cmd(FUNC_PAUSE, 770, 1'b0);
        queue_cmd(FUNC_PASS, 16'h5a5a, 1'b0);
        queue_cmd(FUNC_PAUSE, 882, 1'b0);
        queue_cmd(FUNC_FLUSH, 0, 1'b0);
        queue_cmd(FUNC_PAUSE, 1764, 1'b0);
        queue_cmd(FUNC_FLUSH, 0, 1'b0);
        queue_cmd(FUNC_PAUSE, 16, 1'b0);
        queue_cmd(FUNC_FLUSH, 0, 1'b0);
        queue_cmd(FUNC_PAUSE, 1, 1'b0);
        queue_cmd(FUNC_PASS, 16'ha5a5, 1'b0);
        queue_cmd(FUNC_PAUSE, 17, 1'b0);
        queue_cmd(FUNC_FLUSH, 0, 1'b0);
        queue_cmd(FUNC_PAUSE, 16'hffff, 1'b0);
        queue_cmd(FUNC_PAUSE, 1, 1'b0);
        queue_cmd(FUNC_FLUSH, 0, 1'b0);
        queue_cmd(FUNC_PAUSE, 16'hffff, 1'b0);
        queue_cmd(FUNC_PASS, 16'h8001, 1'b1);
        queue_cmd(FUNC_FLUSH, 0, 1'b0);

        // saturating run first, then random sequences
        for (i = 0; i < 33; i++)
            queue_cmd(FUNC_PAUSE, 16'hffff, 1'b0);
        queue_cmd(FUNC_PASS, $urandom_range(0, 65535), 1'b1);
        while (words_queued < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                k = $urandom_range(0, 4);
                for (i = 0; i < k; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: queue_cmd(FUNC_PAUSE, $urandom_range(0, 65535), 1'b0);
                        1: queue_cmd(FUNC_PAUSE, $urandom_range(0, 20), 1'b0);
                        2: queue_cmd(FUNC_PAUSE, 65535, 1'b0);
                        default: queue_cmd(FUNC_PAUSE, $urandom_range(700, 1800), 1'b0);
                    endcase
                end
                queue_end_word();
            end
            else if (r < 62)
            begin
                queue_total(special_total($urandom_range(0, 20)));
                queue_end_word();
            end
            else if (r < 67)
            begin
                k = $urandom_range(20, 40);
                for (i = 0; i < k; i++)
                    queue_cmd(FUNC_PAUSE, $urandom_range(0, 3) != 0 ? 65535
                                                              : $urandom_range(0, 65535), 1'b0);
                queue_end_word();
            end
            else
                queue_cmd(func_t'($urandom_range(0, 3)), $urandom_range(0, 65535), 1'b0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted < words_queued)
            @(posedge clk);
        while (enc_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (enc_due.size() != 0)
        begin
            $error("%0d result words never arrived", enc_due.size());
            errors++;
        end

        $display("%0d words in, %0d results: wait16 %0d, 60th %0d, 50th %0d, short %0d, pass %0d",
                 words_accepted, results_seen, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3], kind_seen[4]);
        $display("pause total clipped at full scale %0d times, longest result burst %0d words",
                 clips, longest_burst);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pmwe_pkg.sv
hw/rtl/pmwe_queue.sv
hw/rtl/pmwe_front.sv
hw/rtl/pmwe_back.sv
hw/rtl/pause_merge_wait_encoder.sv
tb/tb.sv
